>>> sv/mme_pkg.sv
package mme_pkg;

    localparam int unsigned OPERAND_WIDTH_DEF = 31;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_REDUCE = 5'b00010,
        ST_MUL    = 5'b00100,
        ST_SQR    = 5'b01000,
        ST_DONE   = 5'b10000
    } t_state;

endpackage

>>> sv/mme_mulmod.sv
module mme_mulmod
    import mme_pkg::*;
#(
    parameter int unsigned OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [OPERAND_WIDTH-1:0] i_a,
    input  logic [OPERAND_WIDTH-1:0] i_b,
    input  logic [OPERAND_WIDTH-1:0] i_m,
    output logic                     o_busy,
    output logic                     o_done,
    output logic [OPERAND_WIDTH-1:0] o_result
);

    localparam int unsigned W  = OPERAND_WIDTH;
    localparam int unsigned CW = $clog2(W);

    logic [W-1:0]  r_a;
    logic [W-1:0]  r_b;
    logic [W-1:0]  r_r;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [W+1:0]  dbl_sum;
    logic [W+1:0]  m1;
    logic [W+1:0]  m2;
    logic [W+1:0]  n_r;

    // Horner step over the multiplier bits, MSB first: r = (2r + bit*a) mod m.
    // With r, a < m the sum stays below 3m, so at most 2m is taken off.
    always_comb begin
        m1      = {2'b00, i_m};
        m2      = {1'b0, i_m, 1'b0};
        dbl_sum = {1'b0, r_r, 1'b0} + (r_b[W-1] ? {2'b00, r_a} : '0);
        if (dbl_sum >= m2) begin
            n_r = dbl_sum - m2;
        end else if (dbl_sum >= m1) begin
            n_r = dbl_sum - m1;
        end else begin
            n_r = dbl_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_r   <= '0;
            r_cnt <= CW'(W - 1);
        end else if (r_busy) begin
            r_r   <= n_r[W-1:0];
            r_b   <= {r_b[W-2:0], 1'b0};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_busy   = r_busy;
    assign o_done   = r_done;
    assign o_result = r_r;

endmodule

>>> sv/modular_exponentiation.sv
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_ready    i_base, i_exponent
// result    out        o_valid / i_ready    o_power_mod
// config    in         i_cfg_we             i_cfg_wdata (modulus)
//
// One item at a time. Each modular product runs in the shared bit-serial multiply-reduce
// unit. An item needs one product for the base reduction, one per set exponent bit and
// one square per bit below the top set bit, so at most 2 * W products per item.
// An exponent of zero gives its result in the cycle after acceptance. The result stays
// valid until taken, and o_ready is low from acceptance until then. Reset is
// synchronous and sets the modulus to 1.
module modular_exponentiation
    import mme_pkg::*;
#(
    parameter int unsigned OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [OPERAND_WIDTH-1:0] i_cfg_wdata,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [OPERAND_WIDTH-1:0] i_base,
    input  logic [OPERAND_WIDTH-1:0] i_exponent,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [OPERAND_WIDTH-1:0] o_power_mod
);

    localparam int unsigned W = OPERAND_WIDTH;
    localparam logic [W-1:0] ONE = W'(1);

    t_state       r_state;
    t_state       n_state;
    logic [W-1:0] r_modulus;
    logic [W-1:0] r_base;
    logic [W-1:0] r_exp;
    logic [W-1:0] r_acc;
    logic [W-1:0] r_sq;
    logic         r_start;
    logic         n_start;

    logic [W-1:0] m_eff;
    logic [W-1:0] mm_a;
    logic [W-1:0] mm_b;
    logic         mm_busy;
    logic         mm_done;
    logic [W-1:0] mm_res;
    logic [W-1:0] exp_next;

    // A modulus of zero acts as a modulus of one.
    assign m_eff    = (r_modulus == '0) ? ONE : r_modulus;
    assign exp_next = {1'b0, r_exp[W-1:1]};

    always_comb begin
        unique case (r_state)
            ST_REDUCE: begin
                mm_a = ONE;
                mm_b = r_base;
            end
            ST_MUL: begin
                mm_a = r_acc;
                mm_b = r_sq;
            end
            default: begin
                mm_a = r_sq;
                mm_b = r_sq;
            end
        endcase
    end

    mme_mulmod #(
        .OPERAND_WIDTH(W)
    ) u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_start),
        .i_a      (mm_a),
        .i_b      (mm_b),
        .i_m      (m_eff),
        .o_busy   (mm_busy),
        .o_done   (mm_done),
        .o_result (mm_res)
    );

    always_comb begin
        n_state = r_state;
        n_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_exponent == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_REDUCE;
                        n_start = 1'b1;
                    end
                end
            end
            ST_REDUCE: begin
                if (mm_done) begin
                    n_state = r_exp[0] ? ST_MUL : ST_SQR;
                    n_start = 1'b1;
                end
            end
            ST_MUL: begin
                if (mm_done) begin
                    if (exp_next == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_SQR;
                        n_start = 1'b1;
                    end
                end
            end
            ST_SQR: begin
                // The remaining exponent is nonzero here, so another product follows.
                if (mm_done) begin
                    n_state = exp_next[0] ? ST_MUL : ST_SQR;
                    n_start = 1'b1;
                end
            end
            ST_DONE: begin
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_start   <= 1'b0;
            r_modulus <= ONE;
        end else begin
            r_state <= n_state;
            r_start <= n_start;
            if (i_cfg_we) begin
                r_modulus <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid) begin
            r_base <= i_base;
            r_exp  <= i_exponent;
            r_acc  <= ONE;
        end else if (mm_done) begin
            if (r_state == ST_MUL) begin
                r_acc <= mm_res;
            end else begin
                r_sq <= mm_res;
            end
            if (r_state == ST_SQR) begin
                r_exp <= exp_next;
            end
        end
    end

    assign o_ready     = (r_state == ST_IDLE);
    assign o_valid     = (r_state == ST_DONE);
    assign o_power_mod = r_acc;

    a_result_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_power_mod < m_eff || o_power_mod == ONE))
        else $error("result not reduced below the modulus");

    a_unit_idle_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_DONE) |-> !mm_busy)
        else $error("multiply unit busy while no item is in work");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("block ready again right after accepting an item");

    a_done_while_working: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_done |-> (r_state == ST_REDUCE || r_state == ST_MUL || r_state == ST_SQR))
        else $error("product finished outside a compute state");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top
    import mme_pkg::*;
();

    localparam int unsigned W = OPERAND_WIDTH_DEF;
    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned HOLD_AT_RESULT = 40;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam logic [W-1:0] MAX_VALUE = '1;

    typedef struct packed {
        logic [W-1:0] base;
        logic [W-1:0] exponent;
    } t_operand;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [W-1:0] cfg_wdata = '0;
    logic         in_valid = 1'b0;
    logic         in_ready;
    logic [W-1:0] in_base = '0;
    logic [W-1:0] in_exponent = '0;
    logic         out_valid;
    logic         out_ready = 1'b0;
    logic [W-1:0] out_power_mod;

    t_operand     operand_q[$];
    logic [W-1:0] power_mod_q[$];
    logic [W-1:0] modulus_now = 1;
    logic         idle_on = 1'b0;
    logic         hold_done = 1'b0;
    int unsigned  items_sent = 0;
    int unsigned  results_seen = 0;
    int unsigned  errors = 0;
    int unsigned  send_gap = 0;
    int unsigned  stall_left = 0;
    int unsigned  idle_cycles = 0;
    t_operand     next_item;
    logic [W-1:0] want;

    modular_exponentiation dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_valid     (in_valid),
        .o_ready     (in_ready),
        .i_base      (in_base),
        .i_exponent  (in_exponent),
        .o_valid     (out_valid),
        .i_ready     (out_ready),
        .o_power_mod (out_power_mod)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Right-to-left square-and-multiply. A zero modulus acts as one, and a zero
    // exponent gives 1 without any reduction.
    function automatic logic [W-1:0] power_mod_of(logic [W-1:0] b, logic [W-1:0] e,
                                                  logic [W-1:0] m);
        longint unsigned md;
        longint unsigned acc;
        longint unsigned sq;
        logic [W-1:0]    ex;
        int              i;
        md = (m == 0) ? 64'd1 : 64'(m);
        acc = 1;
        sq = 64'(b) % md;
        ex = e;
        for (i = 0; i < W; i++) begin
            if (ex == 0)
                break;
            if (ex[0])
                acc = (acc * sq) % md;
            ex = ex >> 1;
            sq = (sq * sq) % md;
        end
        return acc[W-1:0];
    endfunction

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 14)
            return $urandom_range(0, 2);
        else if (r < 19)
            return $urandom_range(3, 8);
        else
            return $urandom_range(20, 80);
    endfunction

    function automatic logic [W-1:0] random_base(logic [W-1:0] m);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return m - 1;
            2: return MAX_VALUE;
            3: return m;
            4, 5: return W'($urandom_range(0, 255));
            default: return W'($urandom());
        endcase
    endfunction

    // Most exponents are short to keep the run fast; a few span the full width.
    function automatic logic [W-1:0] random_exponent();
        int unsigned len;
        case ($urandom_range(0, 19))
            0: return '0;
            1: return MAX_VALUE;
            2, 3, 4: return W'($urandom());
            default: begin
                len = $urandom_range(1, 20);
                return W'($urandom()) & ((W'(1) << len) - 1);
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] exp_value);
        $display("ERROR at %0t: %s: got %0d, expected %0d", $realtime, what, got, exp_value);
        errors++;
    endtask

    task automatic push_item(logic [W-1:0] b, logic [W-1:0] e);
        t_operand item;
        item.base = b;
        item.exponent = e;
        operand_q.push_back(item);
        items_sent++;
    endtask

    task automatic wait_drained();
        while (results_seen != items_sent)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_modulus(logic [W-1:0] m);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        modulus_now = m;
    endtask

    // Input side: the expectation is formed when the block takes the item.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (in_valid && in_ready)
                power_mod_q.push_back(power_mod_of(in_base, in_exponent, modulus_now));
            if (in_valid && !in_ready) begin
                // hold the item until it is taken
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end else if (operand_q.size() > 0) begin
                next_item = operand_q.pop_front();
                in_base <= next_item.base;
                in_exponent <= next_item.exponent;
                in_valid <= 1'b1;
                send_gap <= (idle_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result side: check each item against the oldest expectation.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (out_valid && out_ready) begin
                if (power_mod_q.size() == 0) begin
                    report_mismatch("result with nothing expected", out_power_mod, '0);
                end else begin
                    want = power_mod_q.pop_front();
                    if (out_power_mod !== want)
                        report_mismatch("power_mod", out_power_mod, want);
                end
                results_seen++;
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                out_ready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
                // One long hold-off so that the block backs up onto its input.
                hold_done = 1'b1;
                stall_left <= HOLD_CYCLES;
                out_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                stall_left <= gap_len();
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("FAIL modular_exponentiation");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int           phase;
        int           k;
        logic [W-1:0] next_mod;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The modulus comes out of reset as 1; a zero exponent still gives 1.
        push_item(5, 0);
        push_item(5, 3);
        push_item(0, 0);
        push_item(MAX_VALUE, MAX_VALUE);
        wait_drained();

        write_modulus(MAX_VALUE);
        push_item(0, 0);
        push_item(0, 5);
        push_item(MAX_VALUE, 0);
        push_item(MAX_VALUE, MAX_VALUE);
        push_item(1, MAX_VALUE);
        push_item(2, 30);
        push_item(2, 31'h4000_0000);
        push_item(31'h7fff_fffe, 2);
        push_item(12345, 1);
        push_item(31'h5555_5555, 31'h2aaa_aaaa);
        push_item(31'h2aaa_aaaa, 31'h5555_5555);
        wait_drained();

        // A zero modulus behaves like a modulus of one.
        write_modulus(0);
        push_item(7, 0);
        push_item(7, 9);
        push_item(0, 1);

        for (phase = 0; phase < 9; phase++) begin
            case (phase)
                0: next_mod = 1;
                1: next_mod = 2;
                2: next_mod = 3;
                3: next_mod = 31'h7fff_fffe;
                4: next_mod = W'($urandom_range(4, 1000));
                5: next_mod = W'($urandom_range(32'h4000_0000, 32'h7fff_ffff));
                6: next_mod = 65537;
                7: next_mod = W'($urandom());
                default: next_mod = MAX_VALUE;
            endcase
            wait_drained();
            write_modulus(next_mod);
            idle_on = (phase % 3 != 2);
            for (k = 0; k < 30; k++)
                push_item(random_base(next_mod), random_exponent());
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (power_mod_q.size() != 0)
            report_mismatch("expectation never met", '0, power_mod_q[0]);
        if (errors == 0)
            $display("PASS modular_exponentiation");
        else
            $display("FAIL modular_exponentiation");
        $finish;
    end

endmodule
